[hw/rtl/hbridge_motor_speed_ramp_macros.svh]
// assertion macros shared by the speed ramp rtl
// expects aclk and aresetn in the scope of use
`ifndef HBRIDGE_MOTOR_SPEED_RAMP_MACROS_SVH
`define HBRIDGE_MOTOR_SPEED_RAMP_MACROS_SVH

// property that holds at every edge out of reset
`define HMS_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// consequence in the cycle after the antecedent
`define HMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/hms_pkg.sv]
// types and constants for the h-bridge motor speed ramp
// no dependencies
package hms_pkg;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_MOVE = 2'd1,
        OP_STOP = 2'd2
    } op_t;

    localparam logic [1:0] CFG_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_ACCEL    = 2'd1;
    localparam logic [1:0] CFG_DECEL    = 2'd2;

    localparam logic signed [10:0] SPEED_MAX = 11'sd255;
    localparam logic signed [10:0] SPEED_MIN = -11'sd255;
    localparam logic [7:0]         ELAPSED_SAT = 8'd255;

    typedef struct packed {
        logic [7:0] interval_ms;
        logic [7:0] accel_step;
        logic [7:0] decel_step;
    } cfg_t;

    // packed so that pwm_duty sits in the lowest bits
    typedef struct packed {
        logic              stepped;
        logic signed [8:0] current_speed;
        logic              dir_reverse;
        logic              dir_forward;
        logic [7:0]        pwm_duty;
    } res_t;

    localparam int RES_W   = $bits(res_t);
    localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

[hw/rtl/hms_cfg.sv]
// configuration registers of the speed ramp
// depends on hms_pkg
module hms_cfg import hms_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    output cfg_t       cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.interval_ms <= 8'd0;
            cfg_reg.accel_step  <= 8'd1;
            cfg_reg.decel_step  <= 8'd1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_INTERVAL: cfg_reg.interval_ms <= cfg_wdata;
                CFG_ACCEL:    cfg_reg.accel_step  <= cfg_wdata;
                CFG_DECEL:    cfg_reg.decel_step  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/hms_ramp.sv]
// ramp state (speed, elapsed count, held bridge outputs) and one-step update
// depends on hms_pkg and hbridge_motor_speed_ramp_macros.svh
`include "hbridge_motor_speed_ramp_macros.svh"
module hms_ramp import hms_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              in_accept,
    input  logic [1:0]        in_op,
    input  logic signed [8:0] in_target,
    output res_t              res
);

    logic signed [8:0] speed_reg, speed_next;
    logic [7:0]        elapsed_reg, elapsed_next;
    logic [7:0]        duty_reg, duty_next;
    logic [1:0]        dir_reg, dir_next;

    logic signed [10:0] spd, tgt, acc_s, dec_s, nxt, neg;
    logic               due, stepped;

    assign spd   = {{2{speed_reg[8]}}, speed_reg};
    assign acc_s = $signed({3'b000, cfg.accel_step});
    assign dec_s = $signed({3'b000, cfg.decel_step});
    assign due   = (elapsed_reg >= cfg.interval_ms);

    always_comb begin
        tgt = {{2{in_target[8]}}, in_target};
        if (tgt < SPEED_MIN) begin
            tgt = SPEED_MIN;
        end
        nxt          = spd;
        neg          = 11'sd0;
        stepped      = 1'b0;
        elapsed_next = elapsed_reg;
        duty_next    = duty_reg;
        dir_next     = dir_reg;
        unique case (in_op)
            OP_TICK: begin
                if (elapsed_reg != ELAPSED_SAT) begin
                    elapsed_next = elapsed_reg + 8'd1;
                end
            end
            OP_MOVE: begin
                if (due) begin
                    stepped      = 1'b1;
                    elapsed_next = 8'd0;
                    if (tgt > spd) begin
                        nxt = spd + acc_s;
                        if (nxt > tgt) begin
                            nxt = tgt;
                        end
                    end else if (tgt < spd) begin
                        nxt = (spd > 11'sd0) ? spd - dec_s : spd - acc_s;
                        if (nxt < tgt) begin
                            nxt = tgt;
                        end
                    end
                end
                if (nxt > 11'sd0) begin
                    duty_next = nxt[7:0];
                    dir_next  = 2'b01;
                end else if (nxt < 11'sd0) begin
                    neg       = -nxt;
                    duty_next = neg[7:0];
                    dir_next  = 2'b10;
                end else begin
                    duty_next = 8'd0;
                    dir_next  = 2'b00;
                end
            end
            OP_STOP: begin
                if (due) begin
                    stepped      = 1'b1;
                    elapsed_next = 8'd0;
                    if (spd > 11'sd0) begin
                        nxt = spd - dec_s;
                        if (nxt < 11'sd0) begin
                            nxt = 11'sd0;
                        end
                    end else if (spd < 11'sd0) begin
                        nxt = spd + dec_s;
                        if (nxt > 11'sd0) begin
                            nxt = 11'sd0;
                        end
                    end
                end
            end
            default: ;
        endcase
        speed_next = nxt[8:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg   <= 9'sd0;
            elapsed_reg <= ELAPSED_SAT;
            duty_reg    <= 8'd0;
            dir_reg     <= 2'b00;
        end else if (in_accept) begin
            speed_reg   <= speed_next;
            elapsed_reg <= elapsed_next;
            duty_reg    <= duty_next;
            dir_reg     <= dir_next;
        end
    end

    assign res.stepped       = stepped;
    assign res.current_speed = speed_next;
    assign res.dir_reverse   = dir_next[1];
    assign res.dir_forward   = dir_next[0];
    assign res.pwm_duty      = duty_next;

    `HMS_ASSERT_ALWAYS(a_speed_range,
        (speed_reg >= -9'sd255) && (speed_reg <= 9'sd255), "speed out of range")
    `HMS_ASSERT_ALWAYS(a_dir_exclusive, !(dir_reg[0] && dir_reg[1]), "both bridge inputs high")
    `HMS_ASSERT_ALWAYS(a_duty_matches_dir, (duty_reg == 8'd0) == (dir_reg == 2'b00),
        "duty and direction disagree")
    `HMS_ASSERT_NEXT(a_step_restarts, in_accept && stepped, elapsed_reg == 8'd0,
        "elapsed count not restarted")

endmodule

[hw/rtl/hms_out_queue.sv]
// two-word result queue between the ramp update and the master side
// depends on hms_pkg
module hms_out_queue import hms_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  res_t push_data,
    output logic ready,
    output logic valid,
    input  logic pop,
    output res_t head
);

    res_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    assign do_pop = pop && valid;
    assign ready  = (count_reg != 2'd2);
    assign valid  = (count_reg != 2'd0);
    assign head   = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hw/rtl/hbridge_motor_speed_ramp.sv]
// top level of the h-bridge motor speed ramp
// depends on hms_pkg, hms_cfg, hms_ramp and hms_out_queue
//
// s_ side takes one word per item: s_tuser holds the op (tick, move, stop),
// s_tdata the signed target speed used by a move. m_ side returns exactly one
// word per accepted item, in order: duty, direction bits, new speed and a
// flag telling whether a ramp step was taken.
// cfg_we/cfg_index/cfg_wdata write interval_ms (0), accel_step (1) and
// decel_step (2); other indexes are dropped. Write only while idle.
// The result for an accepted item is pushed into the result queue at the
// accept edge. Throughput: one item per cycle while s_tready is high; the
// speed and count registers are updated at the accept edge, so each item
// sees the state left by the one before it without any wait.
// A two-word result queue sits on the master side: s_tready stays high while
// at most one result waits, so the block keeps taking items while the
// receiver stalls, and drops s_tready once two results wait.
// Reset (aresetn low, synchronous): speed 0, bridge outputs low, elapsed
// count saturated at 255 so the first ramp step happens at once, interval 0,
// both step sizes 1, result queue empty.
module hbridge_motor_speed_ramp import hms_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_wdata,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [15:0]        s_tdata,   // [8:0] target_speed
    input  logic [1:0]         s_tuser,   // [1:0] op
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata    // [7:0] pwm_duty, [8] dir_forward,
                                          // [9] dir_reverse, [18:10] current_speed,
                                          // [19] stepped
);

    cfg_t cfg;
    res_t res, head;
    logic s_accept;

    assign s_accept = s_tvalid && s_tready;

    hms_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    hms_ramp u_ramp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_accept (s_accept),
        .in_op     (s_tuser),
        .in_target ($signed(s_tdata[8:0])),
        .res       (res)
    );

    hms_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_accept),
        .push_data (res),
        .ready     (s_tready),
        .valid     (m_tvalid),
        .pop       (m_tready),
        .head      (head)
    );

    assign m_tdata = {{(TDATA_W - RES_W){1'b0}}, head};

endmodule
